[rtl/core/fmf_pkg.sv]
// Shared types, constants and helpers for the magnetic field to force block.
// Used by force_from_magnetic_field and its port checker.
`timescale 1ns / 1ps

package fmf_pkg;

    // fixed-point formats
    localparam int COEF_FRAC_BITS  = 20;
    localparam int FORCE_FRAC_BITS = 16;
    localparam int MONO_FRAC       = 8;
    localparam int COEF_COUNT      = 20;
    localparam int MONO_COUNT      = 10;

    // accumulator to force scaling: floor shift right, or left when negative
    localparam int NARROW_SHIFT = COEF_FRAC_BITS + MONO_FRAC - FORCE_FRAC_BITS;
    localparam int RSH = (NARROW_SHIFT > 0) ? NARROW_SHIFT : 0;
    localparam int LSH = (NARROW_SHIFT < 0) ? -NARROW_SHIFT : 0;

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int FORCE_W  = 32;
    localparam int COEF_W   = 32;
    localparam int CIDX_W   = 5;
    localparam int MONO_W   = 57;            // largest monomial is below 2^55
    localparam int MAG_W    = MONO_W - 1;
    localparam int OPB_W    = COEF_W + 1;
    localparam int HALF_W   = 32;
    localparam int P_MAG_W  = MAG_W + HALF_W;
    localparam int P_W      = P_MAG_W + 1;
    localparam int ACC_W    = P_W + 4;       // ten terms
    localparam int WIDE_W   = ACC_W + LSH;
    localparam int NSQ_W    = 48;            // (x^2 + y^2) << 16
    localparam int ROOT_W   = NSQ_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SUB_W    = REM_W + 2;
    localparam int DVD_W    = 55;            // |radial * a8| < 2^55
    localparam int CNT_W    = 6;
    localparam int STEP_W   = 5;
    localparam int MIDX_W   = 4;
    localparam int CFG_IDX_W = 2;

    // input kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

    // sequencer program steps: one multiplication each
    localparam logic [STEP_W-1:0] STEP_XX      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_YY      = 5'd1;
    localparam logic [STEP_W-1:0] STEP_RR      = 5'd2;
    localparam logic [STEP_W-1:0] STEP_RZ      = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ZZ      = 5'd4;
    localparam logic [STEP_W-1:0] STEP_RRR     = 5'd5;
    localparam logic [STEP_W-1:0] STEP_RZR     = 5'd6;
    localparam logic [STEP_W-1:0] STEP_ZZR     = 5'd7;
    localparam logic [STEP_W-1:0] STEP_ZZZ     = 5'd8;
    localparam logic [STEP_W-1:0] STEP_RAD0    = 5'd9;
    localparam logic [STEP_W-1:0] STEP_AX0     = 5'd19;
    localparam logic [STEP_W-1:0] STEP_AX_LAST = 5'd28;
    localparam logic [STEP_W-1:0] STEP_SPLIT_X = 5'd29;
    localparam logic [STEP_W-1:0] STEP_SPLIT_Y = 5'd30;

    localparam logic [MIDX_W-1:0] MONO_ONE = 4'd0;
    localparam logic [MIDX_W-1:0] MONO_R   = 4'd1;
    localparam logic [MIDX_W-1:0] MONO_Z   = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MLO,
        ST_MHI,
        ST_WB,
        ST_SQRT,
        ST_AXIAL,
        ST_DIV,
        ST_OUT
    } fmf_state_t;

    // scale the polynomial sum and saturate to 32 bits
    function automatic logic signed [FORCE_W-1:0] narrow(input logic signed [ACC_W-1:0] acc);
        logic signed [WIDE_W-1:0] w;
        logic                     fits;
        begin
            w = WIDE_W'(acc);
            w = (w <<< LSH) >>> RSH;
            fits = (&w[WIDE_W-1:FORCE_W-1]) || ~(|w[WIDE_W-1:FORCE_W-1]);
            if (fits)
                narrow = w[FORCE_W-1:0];
            else if (w[WIDE_W-1])
                narrow = {1'b1, {(FORCE_W-1){1'b0}}};
            else
                narrow = {1'b0, {(FORCE_W-1){1'b1}}};
        end
    endfunction

endpackage

[rtl/core/force_from_magnetic_field.sv]
// Magnetic field sample to three-axis force converter, top level.
// Depends on fmf_pkg for widths, step codes, state type and saturation.
`timescale 1ns / 1ps

// Usage:
//   s_* channel: one transaction per item. s_tuser[0] = operation
//   (0 sample, 1 coefficient write), s_tuser[1] = sensor error flag.
//   A coefficient write loads table slot coef_index, no result.
//   A sample with the error flag gives the held forces with status 1.
//   A good sample gives one result on m_* (m_tuser = status 0).
//   cfg_we/cfg_index/cfg_data write the x/y/z offsets, write only, idle only.
// Datapath:
//   Each product is formed in halves: low in ST_MLO, high in ST_MHI, then
//   written back in ST_WB; a sample with x and y nonzero needs 31 of them.
//   The square root and both divisions work bit by bit on one shared
//   subtractor. A sample with x = y = 0 skips the divisions, an error sample
//   the whole datapath. s_tready is low while a sample is being worked on.
// Reset: held forces and offsets clear; the coefficient table is undefined
//   until written. A result waits in the output register while m_tready is
//   low; the next item may be accepted meanwhile, and its result waits
//   until the register is free.
module force_from_magnetic_field (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_x, sample_y, sample_z, coef_index, coef_value, zero pad
    input  logic [87:0] s_tdata,
    // operation, sensor_error
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // force_x, force_y, force_z
    output logic [95:0] m_tdata,
    // status
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = fmf_pkg::SAMPLE_W;
    localparam int FW = fmf_pkg::FORCE_W;

    fmf_pkg::fmf_state_t state_reg, state_next;

    // input fields
    logic                         in_op;
    logic                         in_err;
    logic signed [SW-1:0]         in_x, in_y, in_z;
    logic [fmf_pkg::CIDX_W-1:0]   in_cidx;
    logic [fmf_pkg::COEF_W-1:0]   in_coef;
    logic signed [SW-1:0]         cx, cy, cz;
    logic                         accept;

    assign in_op   = s_tuser[0];
    assign in_err  = s_tuser[1];
    assign in_x    = s_tdata[15:0];
    assign in_y    = s_tdata[31:16];
    assign in_z    = s_tdata[47:32];
    assign in_cidx = s_tdata[52:48];
    assign in_coef = s_tdata[84:53];
    assign accept  = s_tvalid && s_tready;

    // control and state registers
    logic signed [SW-1:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic signed [FW-1:0] held_x_reg, held_y_reg, held_z_reg;
    logic                 out_valid_reg;
    logic [fmf_pkg::STEP_W-1:0] step_reg, step_next;
    logic [fmf_pkg::CNT_W-1:0]  cnt_reg;

    // payload registers
    logic signed [SW-1:0]          x_reg, y_reg, z_reg;
    logic                          xy_nz_reg;
    logic                          err_reg;
    logic signed [fmf_pkg::MONO_W-1:0] mono_reg [fmf_pkg::MONO_COUNT];
    logic [fmf_pkg::COEF_W-1:0]    coef_mem [fmf_pkg::COEF_COUNT];
    logic signed [fmf_pkg::COEF_W-1:0] coef_rd_reg;
    logic [2*fmf_pkg::HALF_W-1:0]  plo_reg;
    logic [fmf_pkg::MAG_W-fmf_pkg::HALF_W-1:0] ahi_reg;
    logic [fmf_pkg::HALF_W-1:0]    bm_reg;
    logic                          mneg_reg;
    logic signed [fmf_pkg::P_W-1:0]   p_reg;
    logic signed [fmf_pkg::ACC_W-1:0] acc_reg;
    logic signed [FW-1:0]          radial_reg;
    logic [fmf_pkg::NSQ_W-1:0]     nsq_reg;
    logic [fmf_pkg::ROOT_W-1:0]    root_reg;
    logic [fmf_pkg::REM_W-1:0]     rem_reg;
    logic [fmf_pkg::DVD_W-1:0]     dvd_reg;
    logic                          sneg_reg;
    logic [FW-1:0]                 out_x_reg, out_y_reg, out_z_reg;
    logic                          out_st_reg;

    assign cx = in_x - offset_x_reg;
    assign cy = in_y - offset_y_reg;
    assign cz = in_z - offset_z_reg;

    // Q8 views of the corrected sample and the root
    logic signed [SW+fmf_pkg::MONO_FRAC-1:0] x8, y8, z8;
    logic signed [fmf_pkg::MONO_W-1:0]       r8_m;
    assign x8   = {x_reg, {fmf_pkg::MONO_FRAC{1'b0}}};
    assign y8   = {y_reg, {fmf_pkg::MONO_FRAC{1'b0}}};
    assign z8   = {z_reg, {fmf_pkg::MONO_FRAC{1'b0}}};
    assign r8_m = fmf_pkg::MONO_W'({1'b0, root_reg});

    // multiplier operand select
    logic [fmf_pkg::MIDX_W-1:0]       mono_idx;
    logic signed [fmf_pkg::MONO_W-1:0] op_a;
    logic signed [fmf_pkg::OPB_W-1:0]  op_b;
    logic signed [fmf_pkg::MONO_W-1:0] neg_a;
    logic signed [fmf_pkg::OPB_W-1:0]  neg_b;
    logic [fmf_pkg::MAG_W-1:0]         a_mag;
    logic [fmf_pkg::HALF_W-1:0]        b_mag;

    assign mono_idx = (step_reg < fmf_pkg::STEP_AX0)
                    ? fmf_pkg::MIDX_W'(step_reg - fmf_pkg::STEP_RAD0)
                    : fmf_pkg::MIDX_W'(step_reg - fmf_pkg::STEP_AX0);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (step_reg >= fmf_pkg::STEP_RAD0 && step_reg <= fmf_pkg::STEP_AX_LAST)
        begin
            op_a = mono_reg[mono_idx];
            op_b = fmf_pkg::OPB_W'(coef_rd_reg);
        end
        else
        begin
            case (step_reg)
                fmf_pkg::STEP_XX:
                begin
                    op_a = fmf_pkg::MONO_W'(x_reg);
                    op_b = fmf_pkg::OPB_W'(x_reg);
                end
                fmf_pkg::STEP_YY:
                begin
                    op_a = fmf_pkg::MONO_W'(y_reg);
                    op_b = fmf_pkg::OPB_W'(y_reg);
                end
                fmf_pkg::STEP_RR:
                begin
                    op_a = r8_m;
                    op_b = fmf_pkg::OPB_W'(r8_m);
                end
                fmf_pkg::STEP_RZ:
                begin
                    op_a = r8_m;
                    op_b = fmf_pkg::OPB_W'(z8);
                end
                fmf_pkg::STEP_ZZ:
                begin
                    op_a = fmf_pkg::MONO_W'(z8);
                    op_b = fmf_pkg::OPB_W'(z8);
                end
                fmf_pkg::STEP_RRR:
                begin
                    op_a = mono_reg[3];
                    op_b = fmf_pkg::OPB_W'(r8_m);
                end
                fmf_pkg::STEP_RZR:
                begin
                    op_a = mono_reg[4];
                    op_b = fmf_pkg::OPB_W'(r8_m);
                end
                fmf_pkg::STEP_ZZR:
                begin
                    op_a = mono_reg[5];
                    op_b = fmf_pkg::OPB_W'(r8_m);
                end
                fmf_pkg::STEP_ZZZ:
                begin
                    op_a = mono_reg[5];
                    op_b = fmf_pkg::OPB_W'(z8);
                end
                fmf_pkg::STEP_SPLIT_X:
                begin
                    op_a = fmf_pkg::MONO_W'(radial_reg);
                    op_b = fmf_pkg::OPB_W'(x8);
                end
                fmf_pkg::STEP_SPLIT_Y:
                begin
                    op_a = fmf_pkg::MONO_W'(radial_reg);
                    op_b = fmf_pkg::OPB_W'(y8);
                end
                default:
                begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    assign neg_a = -op_a;
    assign neg_b = -op_b;
    assign a_mag = op_a[fmf_pkg::MONO_W-1] ? neg_a[fmf_pkg::MAG_W-1:0]
                                           : op_a[fmf_pkg::MAG_W-1:0];
    assign b_mag = op_b[fmf_pkg::OPB_W-1] ? neg_b[fmf_pkg::HALF_W-1:0]
                                          : op_b[fmf_pkg::HALF_W-1:0];

    // high half of the product, combined with the low half
    logic [fmf_pkg::MAG_W-1:0]      phi_mag;
    logic [fmf_pkg::P_MAG_W-1:0]    pmag;
    logic signed [fmf_pkg::P_W-1:0] pext;
    assign phi_mag = ahi_reg * bm_reg;
    assign pmag = {phi_mag, {fmf_pkg::HALF_W{1'b0}}}
                + fmf_pkg::P_MAG_W'(plo_reg);
    assign pext = {1'b0, pmag};

    // shared subtractor for square root and division
    logic [fmf_pkg::SUB_W-1:0] sub_a, sub_b;
    logic [fmf_pkg::SUB_W:0]   diff;
    logic                      ge;
    always_comb
    begin
        if (state_reg == fmf_pkg::ST_SQRT)
        begin
            sub_a = {rem_reg, nsq_reg[fmf_pkg::NSQ_W-1 -: 2]};
            sub_b = fmf_pkg::SUB_W'({root_reg, 2'b01});
        end
        else
        begin
            sub_a = fmf_pkg::SUB_W'({rem_reg[fmf_pkg::REM_W-2:0],
                                     dvd_reg[fmf_pkg::DVD_W-1]});
            sub_b = fmf_pkg::SUB_W'(root_reg);
        end
    end
    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[fmf_pkg::SUB_W];

    // quotient with its sign, saturated
    logic [fmf_pkg::DVD_W-1:0] quot;
    logic [FW-1:0]             qneg;
    logic signed [FW-1:0]      split_val;
    assign quot = {dvd_reg[fmf_pkg::DVD_W-2:0], ge};
    assign qneg = -quot[FW-1:0];
    always_comb
    begin
        if (!sneg_reg)
            split_val = (quot > fmf_pkg::DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                               : quot[FW-1:0];
        else
            split_val = (quot > fmf_pkg::DVD_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                                 : qneg;
    end

    logic signed [FW-1:0] acc_narrow;
    assign acc_narrow = fmf_pkg::narrow(acc_reg);

    logic out_load;
    assign out_load = !out_valid_reg || m_tready;

    logic [fmf_pkg::CIDX_W-1:0] rd_idx;
    assign rd_idx = step_next - fmf_pkg::STEP_RAD0;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            fmf_pkg::ST_IDLE:
            begin
                if (accept && in_op == fmf_pkg::OP_SAMPLE)
                begin
                    step_next  = fmf_pkg::STEP_XX;
                    state_next = in_err ? fmf_pkg::ST_OUT : fmf_pkg::ST_MLO;
                end
            end
            fmf_pkg::ST_MLO:
                state_next = fmf_pkg::ST_MHI;
            fmf_pkg::ST_MHI:
                state_next = fmf_pkg::ST_WB;
            fmf_pkg::ST_WB:
            begin
                case (step_reg)
                    fmf_pkg::STEP_YY:
                    begin
                        state_next = fmf_pkg::ST_SQRT;
                        step_next  = step_reg + 1'b1;
                    end
                    fmf_pkg::STEP_AX_LAST:
                    begin
                        state_next = fmf_pkg::ST_AXIAL;
                        step_next  = step_reg + 1'b1;
                    end
                    fmf_pkg::STEP_SPLIT_X, fmf_pkg::STEP_SPLIT_Y:
                        state_next = fmf_pkg::ST_DIV;
                    default:
                    begin
                        state_next = fmf_pkg::ST_MLO;
                        step_next  = step_reg + 1'b1;
                    end
                endcase
            end
            fmf_pkg::ST_SQRT:
            begin
                if (cnt_reg == '0)
                    state_next = fmf_pkg::ST_MLO;
            end
            fmf_pkg::ST_AXIAL:
                state_next = xy_nz_reg ? fmf_pkg::ST_MLO : fmf_pkg::ST_OUT;
            fmf_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (step_reg == fmf_pkg::STEP_SPLIT_X)
                    begin
                        state_next = fmf_pkg::ST_MLO;
                        step_next  = fmf_pkg::STEP_SPLIT_Y;
                    end
                    else
                        state_next = fmf_pkg::ST_OUT;
                end
            end
            fmf_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = fmf_pkg::ST_IDLE;
            end
            default:
                state_next = fmf_pkg::ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == fmf_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmf_pkg::ST_IDLE;
            step_reg      <= fmf_pkg::STEP_XX;
            out_valid_reg <= 1'b0;
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            offset_z_reg  <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_z_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    fmf_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                    fmf_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                    fmf_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == fmf_pkg::ST_OUT && out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (state_reg == fmf_pkg::ST_AXIAL)
                held_z_reg <= acc_narrow;
            if (state_reg == fmf_pkg::ST_DIV && cnt_reg == '0)
            begin
                if (step_reg == fmf_pkg::STEP_SPLIT_X)
                    held_x_reg <= split_val;
                else
                    held_y_reg <= split_val;
            end
        end
    end

    // coefficient table
    always_ff @(posedge clk)
    begin
        if (accept && in_op == fmf_pkg::OP_COEF && in_cidx < fmf_pkg::CIDX_W'(fmf_pkg::COEF_COUNT))
            coef_mem[in_cidx] <= in_coef;
        if (rd_idx < fmf_pkg::CIDX_W'(fmf_pkg::COEF_COUNT))
            coef_rd_reg <= coef_mem[rd_idx];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fmf_pkg::ST_IDLE:
            begin
                x_reg     <= cx;
                y_reg     <= cy;
                z_reg     <= cz;
                xy_nz_reg <= (cx != '0) || (cy != '0);
                mono_reg[fmf_pkg::MONO_ONE] <= fmf_pkg::MONO_W'(1 << fmf_pkg::MONO_FRAC);
                mono_reg[fmf_pkg::MONO_Z]   <=
                    fmf_pkg::MONO_W'($signed({cz, {fmf_pkg::MONO_FRAC{1'b0}}}));
            end
            fmf_pkg::ST_MLO:
            begin
                plo_reg  <= a_mag[fmf_pkg::HALF_W-1:0] * b_mag;
                ahi_reg  <= a_mag[fmf_pkg::MAG_W-1:fmf_pkg::HALF_W];
                bm_reg   <= b_mag;
                mneg_reg <= op_a[fmf_pkg::MONO_W-1] ^ op_b[fmf_pkg::OPB_W-1];
            end
            fmf_pkg::ST_MHI:
                p_reg <= mneg_reg ? -pext : pext;
            fmf_pkg::ST_WB:
            begin
                if (step_reg == fmf_pkg::STEP_XX)
                    nsq_reg <= {p_reg[31:0], 16'b0};
                else if (step_reg == fmf_pkg::STEP_YY)
                begin
                    nsq_reg  <= nsq_reg + {p_reg[31:0], 16'b0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= fmf_pkg::CNT_W'(fmf_pkg::ROOT_W - 1);
                end
                else if (step_reg <= fmf_pkg::STEP_ZZZ)
                begin
                    mono_reg[fmf_pkg::MIDX_W'(step_reg + 1'b1)] <=
                        fmf_pkg::MONO_W'(p_reg >>> fmf_pkg::MONO_FRAC);
                    if (step_reg == fmf_pkg::STEP_RR)
                        mono_reg[fmf_pkg::MONO_R] <= r8_m;
                end
                else if (step_reg <= fmf_pkg::STEP_AX_LAST)
                begin
                    if (step_reg == fmf_pkg::STEP_RAD0 || step_reg == fmf_pkg::STEP_AX0)
                        acc_reg <= fmf_pkg::ACC_W'(p_reg);
                    else
                        acc_reg <= acc_reg + fmf_pkg::ACC_W'(p_reg);
                    if (step_reg == fmf_pkg::STEP_AX0)
                        radial_reg <= acc_narrow;
                end
                else
                begin
                    dvd_reg  <= p_reg[fmf_pkg::P_W-1] ? fmf_pkg::DVD_W'(-p_reg)
                                                      : fmf_pkg::DVD_W'(p_reg);
                    sneg_reg <= p_reg[fmf_pkg::P_W-1];
                    rem_reg  <= '0;
                    cnt_reg  <= fmf_pkg::CNT_W'(fmf_pkg::DVD_W - 1);
                end
            end
            fmf_pkg::ST_SQRT:
            begin
                rem_reg  <= ge ? diff[fmf_pkg::REM_W-1:0] : sub_a[fmf_pkg::REM_W-1:0];
                root_reg <= {root_reg[fmf_pkg::ROOT_W-2:0], ge};
                nsq_reg  <= {nsq_reg[fmf_pkg::NSQ_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            fmf_pkg::ST_DIV:
            begin
                rem_reg <= ge ? diff[fmf_pkg::REM_W-1:0] : sub_a[fmf_pkg::REM_W-1:0];
                dvd_reg <= quot;
                cnt_reg <= cnt_reg - 1'b1;
            end
            fmf_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_x_reg  <= held_x_reg;
                    out_y_reg  <= held_y_reg;
                    out_z_reg  <= held_z_reg;
                    out_st_reg <= err_reg;
                end
            end
            default: ;
        endcase
        // an error sample skips the datapath; its status comes straight in
        if (accept && in_op == fmf_pkg::OP_SAMPLE)
            err_reg <= in_err;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_st_reg;

endmodule

[rtl/core/fmf_checker.sv]
// Port-level assertions for force_from_magnetic_field, bound to the top level.
// Depends on fmf_pkg for the input kind codes.
`timescale 1ns / 1ps

module fmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // a sample transaction makes the block busy at once
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == fmf_pkg::OP_SAMPLE |=> !s_tready)
        else $error("input still ready after a sample transaction");

    // busy only ever starts with a sample transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tuser[0] == fmf_pkg::OP_SAMPLE))
        else $error("input went busy without a sample transaction");

    // a coefficient write produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] == fmf_pkg::OP_COEF && !m_tvalid |=> !m_tvalid)
        else $error("result appeared after a coefficient write");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind force_from_magnetic_field fmf_checker u_fmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/tb_force_from_magnetic_field.sv]
// Self-checking testbench for force_from_magnetic_field: directed table, then random phases.
// Depends on fmf_pkg and the RTL top; predicts each result in-bench and checks it in order.
`timescale 1ns / 1ps

module tb_force_from_magnetic_field;

    localparam int LIMIT      = 1500000;
    localparam int DRAIN      = 300;
    localparam int PHASES     = 6;
    localparam int PER_PHASE  = 150;

    typedef struct {
        logic               op;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic               err;
        logic [4:0]         idx;
        logic signed [31:0] val;
        logic               fixed;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               st;
    } item_t;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic               st;
    } force_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // sample_x, sample_y, sample_z, coef_index, coef_value, zero pad
    logic [1:0]  s_tuser;   // operation, sensor_error
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // force_x, force_y, force_z
    logic        m_tuser;   // status
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    force_t             pending_forces[$];
    logic signed [31:0] coef_tbl[fmf_pkg::COEF_COUNT];
    logic signed [31:0] held_x, held_y, held_z;
    logic signed [15:0] off_x, off_y, off_z;
    int                 mismatches;
    int                 cycles;
    int                 burst_left;
    int                 hold_cnt;

    force_from_magnetic_field dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic signed [31:0] eval_poly(input int base, input longint mono[10]);
        logic signed [127:0] acc;
        logic signed [127:0] m;
        logic signed [127:0] c;
        begin
            acc = 0;
            for (int i = 0; i < fmf_pkg::MONO_COUNT; i++)
            begin
                m   = mono[i];
                c   = coef_tbl[base + i];
                acc = acc + m * c;
            end
            acc = (acc <<< fmf_pkg::LSH) >>> fmf_pkg::RSH;
            if (acc > 128'sh7FFFFFFF)
                return 32'sh7FFFFFFF;
            if (acc < -128'sh80000000)
                return 32'sh80000000;
            return acc[31:0];
        end
    endfunction

    function automatic logic signed [31:0] split_axis(input logic signed [31:0] radial,
                                                      input longint a8, input longint r8);
        longint          prod;
        longint unsigned q;
        begin
            if (r8 == 0)
                return '0;
            prod = longint'(radial) * a8;
            q    = longint'(prod < 0 ? -prod : prod) / r8;
            if (prod >= 0)
                return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
            return (q > 64'h80000000) ? 32'sh80000000 : 32'(-longint'(q));
        end
    endfunction

    // Updates the in-bench state for one accepted item; queues a result for samples.
    task automatic predict_forces(input item_t it);
        logic signed [15:0] x, y, z;
        longint             x8, y8, z8, r8, radial;
        longint             mono[10];
        force_t             f;
        begin
            if (it.op == fmf_pkg::OP_COEF)
            begin
                if (it.idx < fmf_pkg::COEF_COUNT)
                    coef_tbl[it.idx] = it.val;
                return;
            end
            if (!it.err)
            begin
                x  = it.sx - off_x;
                y  = it.sy - off_y;
                z  = it.sz - off_z;
                x8 = longint'(x) <<< fmf_pkg::MONO_FRAC;
                y8 = longint'(y) <<< fmf_pkg::MONO_FRAC;
                z8 = longint'(z) <<< fmf_pkg::MONO_FRAC;
                r8 = int_sqrt((longint'(x) * x + longint'(y) * y) << (2 * fmf_pkg::MONO_FRAC));
                mono[0] = 64'd1 << fmf_pkg::MONO_FRAC;
                mono[1] = r8;
                mono[2] = z8;
                mono[3] = (r8 * r8) >>> fmf_pkg::MONO_FRAC;
                mono[4] = (r8 * z8) >>> fmf_pkg::MONO_FRAC;
                mono[5] = (z8 * z8) >>> fmf_pkg::MONO_FRAC;
                mono[6] = (mono[3] * r8) >>> fmf_pkg::MONO_FRAC;
                mono[7] = (mono[4] * r8) >>> fmf_pkg::MONO_FRAC;
                mono[8] = (mono[5] * r8) >>> fmf_pkg::MONO_FRAC;
                mono[9] = (mono[5] * z8) >>> fmf_pkg::MONO_FRAC;
                if (!(x == 0 && y == 0))
                begin
                    radial = eval_poly(0, mono);
                    held_x = split_axis(radial[31:0], x8, r8);
                    held_y = split_axis(radial[31:0], y8, r8);
                end
                held_z = eval_poly(fmf_pkg::MONO_COUNT, mono);
            end
            f.fx = held_x;
            f.fy = held_y;
            f.fz = held_z;
            f.st = it.err;
            if (it.fixed)
            begin
                f.fx = it.fx;
                f.fy = it.fy;
                f.fz = it.fz;
                f.st = it.st;
            end
            pending_forces.push_back(f);
        end
    endtask

    task automatic send_item(input item_t it);
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b000, it.val, it.idx, it.sz, it.sy, it.sx};
            s_tuser  <= {it.err, it.op};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_forces(it);
            burst_left--;
        end
    endtask

    // Drops valid and waits until the block is idle; coefficient writes leave no result.
    task automatic wait_idle();
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            while (pending_forces.size() != 0)
                @(posedge clk);
            repeat (DRAIN) @(posedge clk);
        end
    endtask

    task automatic write_offsets(input logic signed [15:0] ox, input logic signed [15:0] oy,
                                 input logic signed [15:0] oz);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= fmf_pkg::REG_OFFSET_X;
            cfg_data  <= ox;
            @(posedge clk);
            cfg_index <= fmf_pkg::REG_OFFSET_Y;
            cfg_data  <= oy;
            @(posedge clk);
            cfg_index <= fmf_pkg::REG_OFFSET_Z;
            cfg_data  <= oz;
            @(posedge clk);
            cfg_we <= 1'b0;
            off_x = ox;
            off_y = oy;
            off_z = oz;
        end
    endtask

    function automatic item_t coef_row(input logic [4:0] idx, input logic signed [31:0] val);
        item_t it;
        begin
            it     = '{default: '0};
            it.op  = fmf_pkg::OP_COEF;
            it.idx = idx;
            it.val = val;
            return it;
        end
    endfunction

    function automatic item_t sample_row(input logic signed [15:0] sx,
                                         input logic signed [15:0] sy,
                                         input logic signed [15:0] sz, input logic err);
        item_t it;
        begin
            it     = '{default: '0};
            it.op  = fmf_pkg::OP_SAMPLE;
            it.sx  = sx;
            it.sy  = sy;
            it.sz  = sz;
            it.err = err;
            return it;
        end
    endfunction

    function automatic item_t fixed_row(input item_t it, input logic signed [31:0] fx,
                                        input logic signed [31:0] fy,
                                        input logic signed [31:0] fz, input logic st);
        begin
            it.fixed = 1'b1;
            it.fx    = fx;
            it.fy    = fy;
            it.fz    = fz;
            it.st    = st;
            return it;
        end
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                it     = coef_row(5'($urandom_range(0, 31)), 32'($urandom));
                it.val = it.val >>> $urandom_range(0, 31);
                it.sx  = 16'($urandom);
                it.sy  = 16'($urandom);
                it.sz  = 16'($urandom);
                it.err = 1'($urandom_range(0, 1));
                return it;
            end
            it     = sample_row(16'($urandom), 16'($urandom), 16'($urandom), pick < 25);
            it.idx = 5'($urandom);
            it.val = 32'($urandom);
            if (pick >= 25 && pick < 32)
            begin
                // x and y land exactly on their offsets
                it.sx = off_x;
                it.sy = off_y;
            end
            else if (pick >= 32 && pick < 40)
            begin
                it.sx = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                it.sy = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                it.sz = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            end
            else if (pick >= 40 && pick < 70)
            begin
                it.sx = off_x + $signed(16'($urandom_range(0, 255))) - 16'sd128;
                it.sy = off_y + $signed(16'($urandom_range(0, 255))) - 16'sd128;
                it.sz = off_z + $signed(16'($urandom_range(0, 255))) - 16'sd128;
            end
            return it;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        force_t f;
        if (m_tvalid && m_tready)
        begin
            if (pending_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h status %b", m_tdata, m_tuser);
            end
            else
            begin
                f = pending_forces.pop_front();
                if (m_tdata[31:0] !== f.fx || m_tdata[63:32] !== f.fy ||
                    m_tdata[95:64] !== f.fz || m_tuser !== f.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch: exp x=%h y=%h z=%h st=%b got x=%h y=%h z=%h st=%b",
                                 f.fx, f.fy, f.fz, f.st, m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[95:64], m_tuser);
                end
            end
        end
    end

    // receiver: stall pattern alternating with clean stretches, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end
        else if (cycles == 30000)
        begin
            hold_cnt <= 3000;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if ((cycles / 5000) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        item_t directed[$];
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        held_x     = '0;
        held_y     = '0;
        held_z     = '0;
        off_x      = '0;
        off_y      = '0;
        off_z      = '0;
        for (int i = 0; i < fmf_pkg::COEF_COUNT; i++)
            coef_tbl[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // error right after reset reports the cleared forces
        directed.push_back(fixed_row(sample_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1),
                                     32'sd0, 32'sd0, 32'sd0, 1'b1));
        // radial = 1.0, axial = -2.0, everything else zero
        for (int i = 0; i < fmf_pkg::COEF_COUNT; i++)
            directed.push_back(coef_row(5'(i), (i == 0) ? 32'sh00100000 :
                                               (i == 10) ? -32'sh00200000 : 32'sh0));
        directed.push_back(coef_row(5'd31, 32'sh7FFFFFFF));   // out-of-range slot ignored
        directed.push_back(fixed_row(sample_row(16'sd3, 16'sd4, 16'sd5, 1'b0),
                                     32'sd39321, 32'sd52428, -32'sd131072, 1'b0));
        // x = y = 0 keeps the split forces
        directed.push_back(fixed_row(sample_row(16'sd0, 16'sd0, 16'sd7, 1'b0),
                                     32'sd39321, 32'sd52428, -32'sd131072, 1'b0));
        directed.push_back(fixed_row(sample_row(16'sh8000, 16'sh8000, 16'sh8000, 1'b1),
                                     32'sd39321, 32'sd52428, -32'sd131072, 1'b1));
        directed.push_back(coef_row(5'd19, 32'sh7FFFFFFF));
        directed.push_back(coef_row(5'd9, 32'sh80000000));
        directed.push_back(sample_row(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0));
        directed.push_back(sample_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0));
        foreach (directed[i])
            send_item(directed[i]);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_offsets(16'sh7FFF, 16'sh8000, 16'sh7FFF);
                1: write_offsets(16'sh8000, 16'sh7FFF, 16'sh8000);
                2: write_offsets(16'sd0, 16'sd0, 16'sd0);
                default: write_offsets(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            for (int n = 0; n < PER_PHASE; n++)
                send_item(random_item());
            wait_idle();
        end

        if (mismatches == 0 && pending_forces.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[force_from_magnetic_field.f]
rtl/core/fmf_pkg.sv
rtl/core/force_from_magnetic_field.sv
rtl/core/fmf_checker.sv
verif/tb_force_from_magnetic_field.sv
